@@ design/bmhpq_pkg.sv @@
// ----------------------------------------------------------------------------
// bmhpq_pkg: shared types and constants for the min-heap priority queue
// Sizes of the slot store, field widths, command/status/register codes and
// the structs that travel between the sequencer and the slot store.
// ----------------------------------------------------------------------------
`default_nettype none

package bmhpq_pkg;

	// store geometry
	localparam int MAX_ENTRIES   = 64;
	localparam int PRIORITY_BITS = 31;
	localparam int IDX_W         = $clog2(MAX_ENTRIES);
	localparam int CNT_W         = $clog2(MAX_ENTRIES + 1);
	localparam int CHILD_W       = IDX_W + 2;

	// fixed field widths
	localparam int ID_W     = 6;
	localparam int PRIO_W   = PRIORITY_BITS;
	localparam int CMD_W    = 2;
	localparam int STATUS_W = 2;
	localparam int LIVE_W   = 7;
	localparam int ENT_W    = 7;

	// configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 31;

	localparam logic [CFG_IDX_W-1:0] REG_ENTRY_COUNT  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_PRIO = CFG_IDX_W'(1);

	localparam logic [PRIO_W-1:0] DEFAULT_PRIO_RST = {{(PRIO_W-1){1'b1}}, 1'b0};

	typedef enum logic [CMD_W-1:0] {
		CMD_INIT     = 2'd0,
		CMD_DECREASE = 2'd1,
		CMD_EXTRACT  = 2'd2,
		CMD_QUERY    = 2'd3
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_DENIED    = 2'd1,
		ST_EMPTY     = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	// one heap slot
	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [PRIO_W-1:0] prio;
	} entry_t;

	// slot store request: write enable, address and data, and read address
	typedef struct packed {
		logic              we;
		logic [IDX_W-1:0]  waddr;
		entry_t            wdata;
		logic [IDX_W-1:0]  raddr;
	} mem_req_t;

endpackage

`default_nettype wire

@@ design/bmhpq_intf.sv @@
// ----------------------------------------------------------------------------
// bmhpq channel interfaces
// Command channel into the queue and response channel out of it, each with
// valid/ready and its payload fields.
// ----------------------------------------------------------------------------
`default_nettype none

interface bmhpq_cmd_if;
	logic                           valid;
	logic                           ready;
	logic [bmhpq_pkg::CMD_W-1:0]    cmd;
	logic [bmhpq_pkg::ID_W-1:0]     entry_id;
	logic [bmhpq_pkg::PRIO_W-1:0]   next_prio;

	modport source (output valid, output cmd, output entry_id, output next_prio,
		input ready);
	modport sink (input valid, input cmd, input entry_id, input next_prio,
		output ready);
endinterface

interface bmhpq_rsp_if;
	logic                            valid;
	logic                            ready;
	logic [bmhpq_pkg::STATUS_W-1:0]  status;
	logic [bmhpq_pkg::ID_W-1:0]      out_id;
	logic [bmhpq_pkg::PRIO_W-1:0]    out_priority;
	logic [bmhpq_pkg::LIVE_W-1:0]    live_count;

	modport source (output valid, output status, output out_id, output out_priority,
		output live_count, input ready);
	modport sink (input valid, input status, input out_id, input out_priority,
		input live_count, output ready);
endinterface

`default_nettype wire

@@ design/bmhpq_store.sv @@
// ----------------------------------------------------------------------------
// bmhpq_store: heap slot store
// One write port and one read port; read data is registered, so a read
// issued in one cycle is visible the next.
// ----------------------------------------------------------------------------
`default_nettype none

module bmhpq_store (
	input  wire                       clk,
	input  wire bmhpq_pkg::mem_req_t  req,
	output bmhpq_pkg::entry_t         rdata
);
	import bmhpq_pkg::*;

	entry_t mem_q [MAX_ENTRIES];
	entry_t rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.waddr] <= req.wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata_q <= mem_q[req.raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

@@ design/binary_min_heap_priority_queue.sv @@
// ----------------------------------------------------------------------------
// binary_min_heap_priority_queue: array min-heap of (id, priority) entries
//
// channel   dir  handshake      payload
// cmd_in    in   valid/ready    cmd, entry_id, next_prio
// rsp_out   out  valid/ready    status, out_id, out_priority, live_count
// cfg       in   cfg_we         cfg_index, cfg_data
//
// One command at a time through the slot store (n = entry_count, saturated).
// Init writes n slots. Decrease/query search up to n slots, then sift up one
// level at a time and place the entry. Extract reads the root and the last
// slot, then sifts down one level at a time and places the entry; empty skips it.
// Each command ends by loading the response register and stalls there while
// an earlier response waits; the next command is taken once it is loaded.
// Reset (arst_n) clears heap size, registers and control only.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_min_heap_priority_queue (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 cfg_we,
	input  wire [bmhpq_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire [bmhpq_pkg::CFG_DATA_W-1:0]     cfg_data,
	bmhpq_cmd_if.sink                           cmd_in,
	bmhpq_rsp_if.source                         rsp_out
);
	import bmhpq_pkg::*;

	typedef enum logic [11:0] {
		S_IDLE   = 12'b0000_0000_0001,
		S_INIT   = 12'b0000_0000_0010,
		S_SRCH   = 12'b0000_0000_0100,
		S_UP_RD  = 12'b0000_0000_1000,
		S_UP_CMP = 12'b0000_0001_0000,
		S_EX_RD0 = 12'b0000_0010_0000,
		S_EX_RDL = 12'b0000_0100_0000,
		S_EX_WL  = 12'b0000_1000_0000,
		S_DN_L   = 12'b0001_0000_0000,
		S_DN_R   = 12'b0010_0000_0000,
		S_DN_CMP = 12'b0100_0000_0000,
		S_DONE   = 12'b1000_0000_0000
	} state_t;

	state_t              state_q;
	cmd_t                cmd_q;
	logic [ID_W-1:0]     vid_q;
	logic [PRIO_W-1:0]   np_q;
	logic [CNT_W-1:0]    lim_q;
	logic [CNT_W-1:0]    size_q;
	logic [CNT_W-1:0]    scan_q;
	logic                pend_q;
	logic [IDX_W-1:0]    pos_q;
	entry_t              cur_q;
	entry_t              left_q;
	status_t             st_q;
	logic [ID_W-1:0]     oid_q;
	logic [PRIO_W-1:0]   oprio_q;

	logic [ENT_W-1:0]    entry_count_q;
	logic [PRIO_W-1:0]   default_prio_q;

	logic                rsp_valid_q;
	status_t             rsp_status_q;
	logic [ID_W-1:0]     rsp_id_q;
	logic [PRIO_W-1:0]   rsp_prio_q;
	logic [LIVE_W-1:0]   rsp_live_q;

	mem_req_t            mem_req;
	entry_t              rd;

	logic                cmd_xfer;
	logic                rsp_load;
	logic                hit;
	logic [CNT_W-1:0]    lim_next;
	logic [CHILD_W-1:0]  lchild_idx;
	logic [CHILD_W-1:0]  rchild_idx;
	logic [IDX_W-1:0]    parent_idx;
	logic                no_left;
	logic                no_right;
	logic                cur_le_rd;
	logic                cur_le_left;
	logic                left_le_rd;
	logic                dn_stay;
	logic                dn_take_left;
	logic                up_stop;

	bmhpq_store u_store (
		.clk   (clk),
		.req   (mem_req),
		.rdata (rd)
	);

	// handshakes
	assign cmd_in.ready = (state_q == S_IDLE);
	assign cmd_xfer     = cmd_in.valid && cmd_in.ready;
	assign rsp_load     = (state_q == S_DONE) && (!rsp_valid_q || rsp_out.ready);

	// search limit: entry_count saturated to the store depth
	assign lim_next = (entry_count_q > ENT_W'(MAX_ENTRIES)) ? CNT_W'(MAX_ENTRIES)
		: CNT_W'(entry_count_q);

	// heap index arithmetic
	assign lchild_idx = (CHILD_W'(pos_q) << 1) + CHILD_W'(1);
	assign rchild_idx = (CHILD_W'(pos_q) << 1) + CHILD_W'(2);
	assign parent_idx = (pos_q - IDX_W'(1)) >> 1;
	assign no_left    = lchild_idx >= CHILD_W'(size_q);
	assign no_right   = rchild_idx >= CHILD_W'(size_q);

	// shared compares
	assign hit          = pend_q && (rd.id == vid_q);
	assign cur_le_rd    = cur_q.prio <= rd.prio;
	assign cur_le_left  = cur_q.prio <= left_q.prio;
	assign left_le_rd   = left_q.prio <= rd.prio;
	assign dn_stay      = cur_le_left && cur_le_rd;
	assign dn_take_left = !cur_le_left && left_le_rd;
	assign up_stop      = rd.prio <= cur_q.prio;

	// slot store access per state
	always_comb begin
		mem_req       = '0;
		mem_req.waddr = pos_q;
		mem_req.wdata = cur_q;
		unique case (state_q)
			S_INIT: begin
				mem_req.we    = (scan_q != lim_q);
				mem_req.waddr = scan_q[IDX_W-1:0];
				mem_req.wdata = '{id: ID_W'(scan_q), prio: default_prio_q};
			end
			S_SRCH: begin
				mem_req.raddr = scan_q[IDX_W-1:0];
			end
			S_UP_RD: begin
				mem_req.raddr = parent_idx;
				mem_req.we    = (pos_q == '0);
			end
			S_UP_CMP: begin
				mem_req.we    = 1'b1;
				mem_req.wdata = up_stop ? cur_q : rd;
			end
			S_EX_RD0: begin
				mem_req.raddr = '0;
			end
			S_EX_RDL: begin
				mem_req.raddr = IDX_W'(size_q - CNT_W'(1));
			end
			S_EX_WL: begin
				// root goes to the old last slot
				mem_req.we    = 1'b1;
				mem_req.waddr = IDX_W'(size_q);
				mem_req.wdata = '{id: oid_q, prio: oprio_q};
			end
			S_DN_L: begin
				mem_req.we    = no_left;
				mem_req.raddr = lchild_idx[IDX_W-1:0];
			end
			S_DN_R: begin
				mem_req.raddr = rchild_idx[IDX_W-1:0];
				mem_req.we    = no_right;
				mem_req.wdata = cur_le_rd ? cur_q : rd;
			end
			S_DN_CMP: begin
				mem_req.we    = 1'b1;
				mem_req.wdata = dn_stay ? cur_q : (dn_take_left ? left_q : rd);
			end
			S_IDLE, S_DONE: begin
			end
			default: begin
			end
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q  <= '0;
			default_prio_q <= DEFAULT_PRIO_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ENTRY_COUNT:  entry_count_q  <= cfg_data[ENT_W-1:0];
				REG_DEFAULT_PRIO: default_prio_q <= cfg_data[PRIO_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			size_q  <= '0;
			scan_q  <= '0;
			pend_q  <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd_xfer) begin
						scan_q <= '0;
						pend_q <= 1'b0;
						unique case (cmd_t'(cmd_in.cmd))
							CMD_INIT:                state_q <= S_INIT;
							CMD_DECREASE, CMD_QUERY: state_q <= S_SRCH;
							CMD_EXTRACT:
								state_q <= (size_q == '0) ? S_DONE : S_EX_RD0;
							default:                 state_q <= S_IDLE;
						endcase
					end
				end
				S_INIT: begin
					if (scan_q == lim_q) begin
						size_q  <= lim_q;
						state_q <= S_DONE;
					end else begin
						scan_q <= scan_q + CNT_W'(1);
					end
				end
				S_SRCH: begin
					if (hit) begin
						if (cmd_q == CMD_DECREASE && np_q < rd.prio) begin
							state_q <= S_UP_RD;
						end else begin
							state_q <= S_DONE;
						end
					end else if (scan_q == lim_q) begin
						state_q <= S_DONE;
					end else begin
						scan_q <= scan_q + CNT_W'(1);
						pend_q <= 1'b1;
					end
				end
				S_UP_RD:  state_q <= (pos_q == '0) ? S_DONE : S_UP_CMP;
				S_UP_CMP: state_q <= up_stop ? S_DONE : S_UP_RD;
				S_EX_RD0: state_q <= S_EX_RDL;
				S_EX_RDL: begin
					size_q  <= size_q - CNT_W'(1);
					state_q <= S_EX_WL;
				end
				S_EX_WL:  state_q <= S_DN_L;
				S_DN_L:   state_q <= no_left ? S_DONE : S_DN_R;
				S_DN_R: begin
					if (!no_right) begin
						state_q <= S_DN_CMP;
					end else begin
						state_q <= cur_le_rd ? S_DONE : S_DN_L;
					end
				end
				S_DN_CMP: state_q <= dn_stay ? S_DONE : S_DN_L;
				S_DONE: begin
					if (rsp_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// per-command working registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (cmd_xfer) begin
					cmd_q   <= cmd_t'(cmd_in.cmd);
					vid_q   <= cmd_in.entry_id;
					np_q    <= cmd_in.next_prio;
					cur_q   <= '{id: cmd_in.entry_id, prio: cmd_in.next_prio};
					lim_q   <= lim_next;
					oid_q   <= '0;
					oprio_q <= '0;
					st_q    <= (cmd_t'(cmd_in.cmd) == CMD_EXTRACT && size_q == '0)
						? ST_EMPTY : ST_OK;
				end
			end
			S_SRCH: begin
				if (hit) begin
					pos_q <= IDX_W'(scan_q - CNT_W'(1));
					oid_q <= vid_q;
					if (cmd_q == CMD_DECREASE && np_q < rd.prio) begin
						oprio_q <= np_q;
					end else begin
						oprio_q <= rd.prio;
						if (cmd_q == CMD_DECREASE) begin
							st_q <= ST_DENIED;
						end
					end
				end else if (scan_q == lim_q) begin
					st_q <= ST_NOT_FOUND;
				end
			end
			S_UP_CMP: begin
				if (!up_stop) begin
					pos_q <= parent_idx;
				end
			end
			S_EX_RDL: begin
				oid_q   <= rd.id;
				oprio_q <= rd.prio;
			end
			S_EX_WL: begin
				cur_q <= rd;
				pos_q <= '0;
			end
			S_DN_R: begin
				left_q <= rd;
				if (no_right && !cur_le_rd) begin
					pos_q <= lchild_idx[IDX_W-1:0];
				end
			end
			S_DN_CMP: begin
				if (!dn_stay) begin
					pos_q <= dn_take_left ? lchild_idx[IDX_W-1:0] : rchild_idx[IDX_W-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_out.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_status_q <= st_q;
			rsp_id_q     <= oid_q;
			rsp_prio_q   <= oprio_q;
			rsp_live_q   <= LIVE_W'(size_q);
		end
	end

	assign rsp_out.valid        = rsp_valid_q;
	assign rsp_out.status       = rsp_status_q;
	assign rsp_out.out_id       = rsp_id_q;
	assign rsp_out.out_priority = rsp_prio_q;
	assign rsp_out.live_count   = rsp_live_q;

`ifndef SYNTHESIS
	a_size_bound: assert property (@(posedge clk) disable iff (!arst_n)
		size_q <= CNT_W'(MAX_ENTRIES))
		else $error("heap size above store depth");

	a_busy_after_xfer: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_xfer |=> !cmd_in.ready)
		else $error("command taken while previous one in flight");

	a_empty_live: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_load |=> (rsp_status_q != ST_EMPTY || rsp_live_q == '0))
		else $error("empty status with nonzero live count");

	a_up_not_root: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_UP_CMP) |-> (pos_q != '0))
		else $error("sift-up compare at root");

	a_hit_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SRCH && hit) |-> (scan_q != '0 && scan_q <= lim_q))
		else $error("search hit outside searched range");
`endif

endmodule

`default_nettype wire
